### hdl/ipv4_tcp_udp_header_parser_unit_macros.svh
// Assertion macros for the IPv4/TCP/UDP header parser checker.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef IPV4_TCP_UDP_HEADER_PARSER_UNIT_MACROS_SVH
`define IPV4_TCP_UDP_HEADER_PARSER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ITHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ITHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ithp_pkg.sv
// Shared types and constants for the IPv4/TCP/UDP header parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ithp_pkg;

  typedef enum logic [2:0] {
    ST_TCP_OK      = 3'd0,
    ST_UDP_OK      = 3'd1,
    ST_NOT_IPV4    = 3'd2,
    ST_SHORT_IP    = 3'd3,
    ST_OTHER_PROTO = 3'd4,
    ST_SHORT_TCP   = 3'd5,
    ST_TRUNCATED   = 3'd6
  } status_t;

  localparam logic [3:0] IP_VERSION4         = 4'd4;
  localparam logic [7:0] PROTO_TCP           = 8'd6;
  localparam logic [7:0] PROTO_UDP           = 8'd17;
  localparam logic [5:0] MIN_IP_HEADER_BYTES = 6'd20;
  localparam logic [3:0] MIN_TCP_WORDS       = 4'd5;
  localparam logic [7:0] BYTE_INDEX_MAX      = 8'd255;

  // Byte positions relative to the IP header start
  localparam logic [8:0] IP_LEN_HI_POS  = 9'd2;
  localparam logic [8:0] IP_LEN_LO_POS  = 9'd3;
  localparam logic [8:0] IP_TTL_POS     = 9'd8;
  localparam logic [8:0] IP_PROTO_POS   = 9'd9;
  localparam logic [8:0] IP_PROTO_END   = 9'd10;
  localparam logic [8:0] IP_ADDR_POS    = 9'd12;
  localparam logic [8:0] IP_ADDR_END    = 9'd20;
  // Byte positions relative to the transport header start
  localparam logic [8:0] L4_PORTS_END   = 9'd4;
  localparam logic [8:0] TCP_SEQACK_END = 9'd12;
  localparam logic [8:0] TCP_OFFSET_POS = 9'd12;
  localparam logic [8:0] TCP_FLAGS_END  = 9'd14;
  localparam logic [8:0] UDP_HEADER_END = 9'd8;

  typedef struct packed {
    logic        step;  // a frame byte is processed this cycle
    logic        last;  // that byte ends the frame
  } step_ctrl_t;

  typedef struct packed {
    logic [7:0]  byte_pos;
    logic [5:0]  ip_header_bytes;
    logic [7:0]  protocol;
    logic        err_flag;
    status_t     err_code;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  ttl;
    logic [15:0] total_length;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] offset_control;
  } frame_state_t;

  localparam frame_state_t FRAME_CLEAR = '0;

  typedef struct packed {
    status_t     status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  ttl;
    logic [15:0] total_length;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [3:0]  data_offset;
    logic [11:0] control;
    logic [7:0]  payload_offset;
  } record_t;

endpackage

`default_nettype wire

### hdl/ipv4_tcp_udp_header_parser_unit.sv
// Top level of the Ethernet/IPv4/TCP/UDP header parser.
// Depends on ithp_pkg, ithp_frame_state and ithp_record_out.
`timescale 1ns / 1ps
`default_nettype none

// Parses one Ethernet frame presented a byte per request, in wire order, with
// frame_last on the final byte, and delivers one header record per frame.
// Throughput is one byte per cycle while in_stall is low: each accepted byte
// goes into an input register and from there updates the frame capture
// registers through a single compare-and-load step. After the last byte has
// passed through the input register, the record is loaded into the output
// register and offered on the output channel from there. Only a last byte can
// be held back: it waits in the input register while a previous record sits
// in the output register with out_stall high, and ordinary bytes keep flowing
// while a record waits. The Ethernet header length is ETH_HEADER_BYTES
// (14 to 22); the ethertype is not checked, only the IP version nibble. Errors
// latch in byte order and the first one wins; any status other than tcp ok or
// udp ok comes with all other record fields zero. Frame state clears after
// every last byte, so frames need no gap between them.
module ipv4_tcp_udp_header_parser_unit #(
  parameter int ETH_HEADER_BYTES = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  parse_status,
  output logic [31:0] source_address,
  output logic [31:0] destination_address,
  output logic [7:0]  time_to_live,
  output logic [15:0] datagram_length,
  output logic [15:0] source_port,
  output logic [15:0] destination_port,
  output logic [31:0] sequence_number,
  output logic [31:0] acknowledge_number,
  output logic [3:0]  data_offset_words,
  output logic [11:0] control_bits,
  output logic [7:0]  payload_offset
);
  import ithp_pkg::*;

  // input register
  logic         held_valid;
  logic [7:0]   held_byte;
  logic         held_last;
  logic         advance;
  logic         in_take;
  step_ctrl_t   ctrl;
  frame_state_t updated;
  record_t      rec;

  // A held last byte needs the output slot empty or draining.
  assign advance  = held_valid && !(held_last && out_valid && out_stall);
  assign in_stall = held_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_byte <= frame_byte;
      held_last <= frame_last;
    end
  end

  assign ctrl.step = advance;
  assign ctrl.last = held_last;

  ithp_frame_state #(
    .ETH_HEADER_BYTES(ETH_HEADER_BYTES)
  ) u_frame_state (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .data    (held_byte),
    .updated (updated)
  );

  ithp_record_out #(
    .ETH_HEADER_BYTES(ETH_HEADER_BYTES)
  ) u_record_out (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .updated (updated),
    .stall   (out_stall),
    .valid   (out_valid),
    .rec     (rec)
  );

  assign parse_status        = rec.status;
  assign source_address      = rec.src_addr;
  assign destination_address = rec.dst_addr;
  assign time_to_live        = rec.ttl;
  assign datagram_length     = rec.total_length;
  assign source_port         = rec.src_port;
  assign destination_port    = rec.dst_port;
  assign sequence_number     = rec.seq_num;
  assign acknowledge_number  = rec.ack_num;
  assign data_offset_words   = rec.data_offset;
  assign control_bits        = rec.control;
  assign payload_offset      = rec.payload_offset;

endmodule

`default_nettype wire

### hdl/ithp_frame_state.sv
// Per-frame capture registers and their byte-indexed update logic.
// Depends on ithp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ithp_frame_state #(
  parameter int ETH_HEADER_BYTES = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ithp_pkg::step_ctrl_t ctrl,
  input  logic [7:0]           data,
  output ithp_pkg::frame_state_t updated
);
  import ithp_pkg::*;

  localparam logic [8:0] ETH = 9'(ETH_HEADER_BYTES);

  frame_state_t state;
  frame_state_t state_next;
  frame_state_t upd;
  logic [8:0]   pos;
  logic [8:0]   t;

  // State after taking the current byte; byte_pos still holds its position.
  always_comb begin
    upd = state;
    pos = {1'b0, state.byte_pos};
    t   = ETH + {3'b000, state.ip_header_bytes};
    if (!state.err_flag && pos >= ETH) begin
      priority if (pos == ETH) begin
        upd.ip_header_bytes = {data[3:0], 2'b00};
        if (data[7:4] != IP_VERSION4) begin
          upd.err_flag = 1'b1;
          upd.err_code = ST_NOT_IPV4;
        end else if ({data[3:0], 2'b00} < MIN_IP_HEADER_BYTES) begin
          upd.err_flag = 1'b1;
          upd.err_code = ST_SHORT_IP;
        end
      end else if (pos == ETH + IP_LEN_HI_POS || pos == ETH + IP_LEN_LO_POS) begin
        upd.total_length = {state.total_length[7:0], data};
        upd.ttl          = '0;
      end else if (pos == ETH + IP_TTL_POS) begin
        upd.ttl = data;
      end else if (pos == ETH + IP_PROTO_POS) begin
        upd.protocol = data;
        if (data != PROTO_TCP && data != PROTO_UDP) begin
          upd.err_flag = 1'b1;
          upd.err_code = ST_OTHER_PROTO;
        end
      end else if (pos >= ETH + IP_ADDR_POS && pos < ETH + IP_ADDR_END) begin
        upd.src_addr = {state.src_addr[23:0], state.dst_addr[31:24]};
        upd.dst_addr = {state.dst_addr[23:0], data};
      end else if (pos >= ETH + IP_ADDR_END && pos >= t) begin
        if (pos < t + L4_PORTS_END) begin
          upd.src_port = {state.src_port[7:0], state.dst_port[15:8]};
          upd.dst_port = {state.dst_port[7:0], data};
        end else if (state.protocol == PROTO_TCP) begin
          if (pos < t + TCP_SEQACK_END) begin
            upd.seq_num = {state.seq_num[23:0], state.ack_num[31:24]};
            upd.ack_num = {state.ack_num[23:0], data};
          end else if (pos < t + TCP_FLAGS_END) begin
            upd.offset_control = {state.offset_control[7:0], data};
            if (pos == t + TCP_OFFSET_POS && data[7:4] < MIN_TCP_WORDS) begin
              upd.err_flag = 1'b1;
              upd.err_code = ST_SHORT_TCP;
            end
          end
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    if (ctrl.step) begin
      if (ctrl.last) begin
        state_next = FRAME_CLEAR;
      end else begin
        state_next = upd;
        if (state.byte_pos != BYTE_INDEX_MAX) begin
          state_next.byte_pos = state.byte_pos + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRAME_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign updated = upd;

endmodule

`default_nettype wire

### hdl/ithp_record_out.sv
// Frame-end status decision and the registered result record with its valid.
// Depends on ithp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ithp_record_out #(
  parameter int ETH_HEADER_BYTES = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ithp_pkg::step_ctrl_t   ctrl,
  input  ithp_pkg::frame_state_t updated,
  input  logic                   stall,
  output logic                   valid,
  output ithp_pkg::record_t      rec
);
  import ithp_pkg::*;

  localparam logic [8:0] ETH = 9'(ETH_HEADER_BYTES);

  record_t    rec_next;
  status_t    status;
  logic [8:0] len;
  logic [8:0] t;
  logic [8:0] need;
  logic [3:0] doff;

  always_comb begin
    len    = {1'b0, updated.byte_pos} + 9'd1;
    t      = ETH + {3'b000, updated.ip_header_bytes};
    doff   = updated.offset_control[15:12];
    need   = '0;
    status = ST_TRUNCATED;
    priority if (updated.err_flag) begin
      status = updated.err_code;
    end else if (len < ETH + IP_PROTO_END) begin
      status = ST_TRUNCATED;
    end else if (updated.protocol == PROTO_TCP) begin
      if (len <= t + TCP_OFFSET_POS) begin
        status = ST_TRUNCATED;
      end else begin
        need   = t + {3'b000, doff, 2'b00};
        status = (len < need) ? ST_TRUNCATED : ST_TCP_OK;
      end
    end else begin
      need   = t + UDP_HEADER_END;
      status = (len < need) ? ST_TRUNCATED : ST_UDP_OK;
    end

    rec_next        = '0;
    rec_next.status = status;
    if (status == ST_TCP_OK || status == ST_UDP_OK) begin
      rec_next.src_addr       = updated.src_addr;
      rec_next.dst_addr       = updated.dst_addr;
      rec_next.ttl            = updated.ttl;
      rec_next.total_length   = updated.total_length;
      rec_next.src_port       = updated.src_port;
      rec_next.dst_port       = updated.dst_port;
      rec_next.payload_offset = need[7:0];
    end
    if (status == ST_TCP_OK) begin
      rec_next.seq_num     = updated.seq_num;
      rec_next.ack_num     = updated.ack_num;
      rec_next.data_offset = doff;
      rec_next.control     = updated.offset_control[11:0];
    end
  end

  // Upstream only steps a last byte when this slot is free or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.step && ctrl.last) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.last) begin
      rec <= rec_next;
    end
  end

endmodule

`default_nettype wire

### hdl/ithp_checker.sv
// Port-level assertions for the header parser, bound to the top level.
// Depends on ithp_pkg and ipv4_tcp_udp_header_parser_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_tcp_udp_header_parser_unit_macros.svh"

module ithp_checker #(
  parameter int ETH_HEADER_BYTES = 14
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  parse_status,
  input logic [31:0] source_address,
  input logic [31:0] destination_address,
  input logic [7:0]  time_to_live,
  input logic [15:0] datagram_length,
  input logic [15:0] source_port,
  input logic [15:0] destination_port,
  input logic [31:0] sequence_number,
  input logic [31:0] acknowledge_number,
  input logic [3:0]  data_offset_words,
  input logic [11:0] control_bits,
  input logic [7:0]  payload_offset
);
  import ithp_pkg::*;

  logic ok_rec;
  logic udp_rec;
  logic err_rec;
  logic tcp_zero;
  logic all_zero;
  logic offset_sane;

  assign ok_rec   = out_valid && (parse_status == ST_TCP_OK || parse_status == ST_UDP_OK);
  assign udp_rec  = out_valid && parse_status == ST_UDP_OK;
  assign err_rec  = out_valid && !(parse_status == ST_TCP_OK || parse_status == ST_UDP_OK);
  assign tcp_zero = sequence_number == '0 && acknowledge_number == '0 &&
                    data_offset_words == '0 && control_bits == '0;
  assign all_zero = tcp_zero && source_address == '0 && destination_address == '0 &&
                    time_to_live == '0 && datagram_length == '0 && source_port == '0 &&
                    destination_port == '0 && payload_offset == '0;
  // a good record's payload lies past the link header and a minimal IP header
  assign offset_sane = {24'd0, payload_offset} >= 32'(ETH_HEADER_BYTES + 20);

  `ITHP_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "record dropped while stalled")
  `ITHP_ASSERT_SAME(a_err_zero, err_rec, all_zero, "error record has nonzero fields")
  `ITHP_ASSERT_SAME(a_udp_zero, udp_rec, tcp_zero, "udp record carries tcp fields")
  `ITHP_ASSERT_SAME(a_ok_offset, ok_rec, offset_sane, "payload offset inside ip header")

endmodule

bind ipv4_tcp_udp_header_parser_unit ithp_checker #(
  .ETH_HEADER_BYTES(ETH_HEADER_BYTES)
) u_checker (.*);

`default_nettype wire
